// ===== hw/rtl/stid_pkg.sv =====
// -----------------------------------------------------------------------------
// stid_pkg
// Shared sizes, codes and types of the sorted record table.
// -----------------------------------------------------------------------------
package stid_pkg;

   // table size and derived widths
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths of the channels
   localparam int KEY_W    = 16;
   localparam int MARK_W   = 7;
   localparam int MARKS_W  = 5 * MARK_W;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 7;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DELETE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // commands broadcast along the cell row
   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // one stored record
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [MARKS_W-1:0] marks;
   } record_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic [1:0]       cmd;
      record_type       rec;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] del_pos;
   } cell_bus_type;

   // binary search outcome
   typedef struct packed {
      logic             hit;
      logic             miss;
      logic [IDX_W-1:0] idx;
   } srch_type;

endpackage

// ===== hw/rtl/stid_req_if.sv =====
// -----------------------------------------------------------------------------
// stid_req_if
// Request channel: insert or delete beat with valid/ready handshake.
// -----------------------------------------------------------------------------
interface stid_req_if;
   import stid_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [KEY_W-1:0]  key;
   logic [MARK_W-1:0] mark_a;
   logic [MARK_W-1:0] mark_b;
   logic [MARK_W-1:0] mark_c;
   logic [MARK_W-1:0] mark_d;
   logic [MARK_W-1:0] mark_e;

   modport source (output valid, req_type, key, mark_a, mark_b, mark_c, mark_d, mark_e,
                   input ready);
   modport sink   (input valid, req_type, key, mark_a, mark_b, mark_c, mark_d, mark_e,
                   output ready);
endinterface

// ===== hw/rtl/stid_rsp_if.sv =====
// -----------------------------------------------------------------------------
// stid_rsp_if
// Result channel: status, position, moves and fill count per request.
// -----------------------------------------------------------------------------
interface stid_rsp_if;
   import stid_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OUT_W-1:0]    position;
   logic [OUT_W-1:0]    moves;
   logic [OUT_W-1:0]    fill_count;

   modport source (output valid, status, position, moves, fill_count, input ready);
   modport sink   (input valid, status, position, moves, fill_count, output ready);
endinterface

// ===== hw/rtl/stid_cell.sv =====
// -----------------------------------------------------------------------------
// stid_cell
// One table slot: holds a record, compares it to the broadcast key and
// takes the new record or its lower neighbor's on insert, its upper neighbor's on delete.
// -----------------------------------------------------------------------------
module stid_cell (
   input  logic                   clock,
   input  stid_pkg::cell_bus_type bus,
   input  logic [stid_pkg::IDX_W-1:0] cell_idx,
   input  logic                   prev_lt,
   input  stid_pkg::record_type   prev_rec,
   input  stid_pkg::record_type   next_rec,
   output stid_pkg::record_type   rec,
   output logic                   lt,
   output logic                   eq
);
   import stid_pkg::*;

   record_type rec_ff;
   record_type rec_in;
   logic       live;
   logic       room;

   // live slot flags and key compares
   assign live = CNT_W'(cell_idx) < bus.count;
   assign room = CNT_W'(cell_idx) <= bus.count;
   assign lt   = live && (rec_ff.key < bus.rec.key);
   assign eq   = live && (rec_ff.key == bus.rec.key);
   assign rec  = rec_ff;

   // shift up on insert, shift down on delete
   always_comb begin
      rec_in = rec_ff;
      case (bus.cmd)
         CMD_INSERT: begin
            if (!lt) begin
               if (prev_lt) begin
                  rec_in = bus.rec;
               end else if (room) begin
                  rec_in = prev_rec;
               end
            end
         end
         CMD_DELETE: begin
            if (cell_idx >= bus.del_pos) begin
               rec_in = next_rec;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ===== hw/rtl/stid_search.sv =====
// -----------------------------------------------------------------------------
// stid_search
// Binary search over the live slots, one probe per cycle while step is high,
// reading the per-cell less-than and equal flags at the midpoint.
// -----------------------------------------------------------------------------
module stid_search (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         step,
   input  logic [stid_pkg::CNT_W-1:0]   count,
   input  logic [stid_pkg::CAPACITY-1:0] lt_vec,
   input  logic [stid_pkg::CAPACITY-1:0] eq_vec,
   output stid_pkg::srch_type           res
);
   import stid_pkg::*;

   // bounds: lo and one past hi
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hip_ff, hip_in;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic             open;

   // midpoint of lo and hi
   assign open    = lo_ff < hip_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip_ff} - (CNT_W + 1)'(1);
   assign mid     = IDX_W'(mid_sum[CNT_W:1]);

   assign res.hit  = open && eq_vec[mid];
   assign res.miss = !open;
   assign res.idx  = mid;

   // narrow the range after each probe
   always_comb begin
      lo_in  = lo_ff;
      hip_in = hip_ff;
      if (start) begin
         lo_in  = '0;
         hip_in = count;
      end else if (step && open && !eq_vec[mid]) begin
         if (lt_vec[mid]) begin
            lo_in = CNT_W'(mid) + CNT_W'(1);
         end else begin
            hip_in = CNT_W'(mid);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff  <= '0;
         hip_ff <= '0;
      end else begin
         lo_ff  <= lo_in;
         hip_ff <= hip_in;
      end
   end

endmodule

// ===== hw/rtl/sorted_table_insert_delete_unit.sv =====
// -----------------------------------------------------------------------------
// sorted_table_insert_delete_unit
// Sorted record table built as a row of cells: insert before the first key
// not less than the new one, delete by binary search, one result per request.
//
//   channel  dir  beat contents
//   req_ch   in   req_type, key, mark_a .. mark_e
//   rsp_ch   out  status, position, moves, fill_count
//
// Insert: the request is registered, then all cells compare and shift at once
// as the result is registered. Delete: a binary search of at most clog2(count)+1
// probes, the search unit stepping one midpoint per cycle, then the shift.
// Reset clears the live count and control; stored records are not cleared.
// A finished result waits in its last state while the result register is full;
// a new request is taken only when the previous one has reached that register.
// -----------------------------------------------------------------------------
module sorted_table_insert_delete_unit (
   input logic       clock,
   input logic       reset,
   stid_req_if.sink  req_ch,
   stid_rsp_if.source rsp_ch
);
   import stid_pkg::*;

   // controller states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_INSERT = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_DELETE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   record_type          op_rec_ff, op_rec_in;
   logic [IDX_W-1:0]    del_pos_ff, del_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [OUT_W-1:0]    rsp_moves_ff, rsp_moves_in;
   logic [OUT_W-1:0]    rsp_fill_ff, rsp_fill_in;

   cell_bus_type        bus;
   record_type          cell_rec [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;
   logic [CAPACITY-1:0] prev_lt_vec;
   logic [IDX_W-1:0]    ins_pos;
   srch_type            srch_res;
   logic                req_beat;
   logic                slot_free;
   logic                full;

   assign req_beat  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign full      = count_ff == CNT_W'(CAPACITY);

   assign req_ch.ready = state_ff == S_IDLE;

   // broadcast to the cell row
   always_comb begin
      bus.rec     = op_rec_ff;
      bus.count   = count_ff;
      bus.del_pos = del_pos_ff;
      bus.cmd     = CMD_HOLD;
      if (state_ff == S_INSERT && slot_free && !full) begin
         bus.cmd = CMD_INSERT;
      end else if (state_ff == S_DELETE && slot_free) begin
         bus.cmd = CMD_DELETE;
      end
   end

   // row of cells
   assign prev_lt_vec = {lt_vec[CAPACITY-2:0], 1'b1};

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      record_type prev_rec;
      record_type next_rec;
      if (g == 0) begin : g_first
         assign prev_rec = '0;
      end else begin : g_mid
         assign prev_rec = cell_rec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_rec = '0;
      end else begin : g_inner
         assign next_rec = cell_rec[g+1];
      end
      stid_cell u_cell (
         .clock    (clock),
         .bus      (bus),
         .cell_idx (IDX_W'(g)),
         .prev_lt  (prev_lt_vec[g]),
         .prev_rec (prev_rec),
         .next_rec (next_rec),
         .rec      (cell_rec[g]),
         .lt       (lt_vec[g]),
         .eq       (eq_vec[g])
      );
   end

   // insert position: the cell where the less-than run ends
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (prev_lt_vec[i] && !lt_vec[i]) begin
            ins_pos = ins_pos | IDX_W'(i);
         end
      end
   end

   // delete lookup
   stid_search u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (req_beat && req_ch.req_type == REQ_DELETE),
      .step   (state_ff == S_SEARCH),
      .count  (count_ff),
      .lt_vec (lt_vec),
      .eq_vec (eq_vec),
      .res    (srch_res)
   );

   // request sequencing and result beat
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      op_rec_in       = op_rec_ff;
      del_pos_in      = del_pos_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_moves_in    = rsp_moves_ff;
      rsp_fill_in     = rsp_fill_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_rec_in.key   = req_ch.key;
               op_rec_in.marks = {req_ch.mark_e, req_ch.mark_d, req_ch.mark_c,
                                  req_ch.mark_b, req_ch.mark_a};
               state_in = (req_ch.req_type == REQ_DELETE) ? S_SEARCH : S_INSERT;
            end
         end
         S_INSERT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (full) begin
                  rsp_status_in   = ST_FULL;
                  rsp_position_in = '0;
                  rsp_moves_in    = '0;
                  rsp_fill_in     = OUT_W'(count_ff);
               end else begin
                  count_in        = count_ff + CNT_W'(1);
                  rsp_status_in   = ST_DONE;
                  rsp_position_in = OUT_W'(ins_pos);
                  rsp_moves_in    = OUT_W'(count_ff - CNT_W'(ins_pos));
                  rsp_fill_in     = OUT_W'(count_ff + CNT_W'(1));
               end
            end
         end
         S_SEARCH: begin
            if (srch_res.miss) begin
               if (slot_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = ST_NOT_FOUND;
                  rsp_position_in = '0;
                  rsp_moves_in    = '0;
                  rsp_fill_in     = OUT_W'(count_ff);
                  state_in        = S_IDLE;
               end
            end else if (srch_res.hit) begin
               del_pos_in = srch_res.idx;
               state_in   = S_DELETE;
            end
         end
         S_DELETE: begin
            if (slot_free) begin
               count_in        = count_ff - CNT_W'(1);
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_DONE;
               rsp_position_in = OUT_W'(del_pos_ff);
               rsp_moves_in    = OUT_W'(count_ff - CNT_W'(1) - CNT_W'(del_pos_ff));
               rsp_fill_in     = OUT_W'(count_ff - CNT_W'(1));
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_rec_ff       <= op_rec_in;
      del_pos_ff      <= del_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_moves_ff    <= rsp_moves_in;
      rsp_fill_ff     <= rsp_fill_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.position   = rsp_position_ff;
   assign rsp_ch.moves      = rsp_moves_ff;
   assign rsp_ch.fill_count = rsp_fill_ff;

   // live count stays within the table
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("live count above capacity");

   // live count moves by at most one per cycle
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) ||
                count_ff == $past(count_ff) + CNT_W'(1) ||
                count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("live count jumped");

   // an accepted insert goes straight to the shift state
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_ch.req_type == REQ_INSERT) |=> state_ff == S_INSERT)
      else $error("insert not sequenced");

   // a search hit always lands on a live slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && srch_res.hit) |-> CNT_W'(srch_res.idx) < count_ff)
      else $error("search hit outside live slots");

endmodule

// ===== dv/sorted_table_insert_delete_unit_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sorted_table_insert_delete_unit_tb
// Self-checking bench for the sorted record table. A shadow table in the bench
// tracks every accepted insert and delete and predicts status, position, moves
// and fill count. Directed cases come first, then a fill-to-full sweep, a long
// result hold-off, and a random mix with idle bursts on both channels.
// -----------------------------------------------------------------------------
module sorted_table_insert_delete_unit_tb;
   import stid_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 32;
   localparam int RANDOM_OPS   = 560;
   localparam int CALM_OPS     = 120;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OUT_W-1:0]    position;
      logic [OUT_W-1:0]    moves;
      logic [OUT_W-1:0]    fill_count;
   } table_rsp_type;

   logic clock;
   logic reset;

   stid_req_if req_bus ();
   stid_rsp_if rsp_bus ();

   sorted_table_insert_delete_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // shadow copy of the table contents
   logic [KEY_W-1:0]   tbl_keys  [CAPACITY];
   logic [MARKS_W-1:0] tbl_marks [CAPACITY];
   int                 tbl_fill;

   table_rsp_type predicted_outcomes [$];
   int            mismatch_count;
   int            cycle_count;
   bit            idle_en;
   int            rsp_hold_request;
   int            rsp_stall_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // apply one request to the shadow table and return its outcome
   function automatic table_rsp_type apply_to_table(input logic op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [MARKS_W-1:0] marks);
      table_rsp_type res;
      int            p;
      int            i;
      int            lo;
      int            hi;
      int            mid;
      int            hit;
      res = '{status: ST_DONE, position: '0, moves: '0, fill_count: '0};
      if (op == REQ_INSERT) begin
         if (tbl_fill >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // first slot whose key is not below the new key
            p = 0;
            while (p < tbl_fill && tbl_keys[p] < key) p++;
            for (i = tbl_fill; i > p; i--) begin
               tbl_keys[i]  = tbl_keys[i-1];
               tbl_marks[i] = tbl_marks[i-1];
            end
            tbl_keys[p]  = key;
            tbl_marks[p] = marks;
            res.position = OUT_W'(p);
            res.moves    = OUT_W'(tbl_fill - p);
            tbl_fill++;
         end
      end else begin
         // midpoint binary search over live entries
         hit = -1;
         lo  = 0;
         hi  = tbl_fill - 1;
         while (lo <= hi && hit < 0) begin
            mid = (lo + hi) / 2;
            if (tbl_keys[mid] == key) hit = mid;
            else if (tbl_keys[mid] > key) hi = mid - 1;
            else lo = mid + 1;
         end
         if (hit < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            for (i = hit; i + 1 < tbl_fill; i++) begin
               tbl_keys[i]  = tbl_keys[i+1];
               tbl_marks[i] = tbl_marks[i+1];
            end
            tbl_keys[tbl_fill-1]  = '0;
            tbl_marks[tbl_fill-1] = '0;
            res.position = OUT_W'(hit);
            res.moves    = OUT_W'(tbl_fill - 1 - hit);
            tbl_fill--;
         end
      end
      res.fill_count = OUT_W'(tbl_fill);
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return KEY_W'($urandom_range(0, 15));
         default: return KEY_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [MARKS_W-1:0] rand_marks();
      return MARKS_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [KEY_W-1:0] pick_stored_key();
      return tbl_keys[$urandom_range(0, tbl_fill - 1)];
   endfunction

   // drive one request beat, wait for accept, then record its outcome
   task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                            input logic [MARKS_W-1:0] marks);
      table_rsp_type outcome;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= op;
      req_bus.key      <= key;
      req_bus.mark_a   <= marks[0*MARK_W +: MARK_W];
      req_bus.mark_b   <= marks[1*MARK_W +: MARK_W];
      req_bus.mark_c   <= marks[2*MARK_W +: MARK_W];
      req_bus.mark_d   <= marks[3*MARK_W +: MARK_W];
      req_bus.mark_e   <= marks[4*MARK_W +: MARK_W];
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      outcome = apply_to_table(op, key, marks);
      predicted_outcomes.push_back(outcome);
   endtask

   // random request, delete-heavy when nearly full, insert-heavy when nearly empty
   task automatic send_random_op();
      logic             op;
      logic [KEY_W-1:0] key;
      int               del_pct;
      del_pct = (tbl_fill < 8) ? 25 : (tbl_fill > CAPACITY - 8) ? 75 : 50;
      op = ($urandom_range(0, 99) < del_pct) ? REQ_DELETE : REQ_INSERT;
      if (tbl_fill > 0 && $urandom_range(0, 99) < ((op == REQ_DELETE) ? 70 : 15))
         key = pick_stored_key();
      else
         key = rand_key();
      send_item(op, key, rand_marks());
   endtask

   // extremes, duplicates, misses and an empty table
   task automatic test_directed();
      send_item(REQ_DELETE, 16'h1234, '0);
      send_item(REQ_INSERT, 16'h8000, '0);
      send_item(REQ_INSERT, 16'h0000, '1);
      send_item(REQ_INSERT, 16'hFFFF, 35'h2_AAAA_AAAA);
      send_item(REQ_INSERT, 16'h8000, 35'h5_5555_5555);
      send_item(REQ_INSERT, 16'h8000, '1);
      send_item(REQ_INSERT, 16'h5555, rand_marks());
      send_item(REQ_INSERT, 16'hAAAA, rand_marks());
      send_item(REQ_INSERT, 16'h0000, rand_marks());
      send_item(REQ_DELETE, 16'h8000, '1);
      send_item(REQ_DELETE, 16'h1234, '0);
      send_item(REQ_DELETE, 16'hFFFF, rand_marks());
      send_item(REQ_DELETE, 16'hFFFF, '0);
      send_item(REQ_DELETE, 16'h0000, '0);
      send_item(REQ_DELETE, 16'h8000, '0);
      send_item(REQ_DELETE, 16'h5555, '0);
      send_item(REQ_DELETE, 16'h8000, '0);
      send_item(REQ_DELETE, 16'hAAAA, '0);
      send_item(REQ_DELETE, 16'h0000, '0);
      send_item(REQ_DELETE, 16'h0000, '0);
      send_item(REQ_INSERT, 16'h7FFF, '1);
   endtask

   // fill to capacity, poke the full table, then drain it
   task automatic test_full_table();
      while (tbl_fill < CAPACITY) send_item(REQ_INSERT, rand_key(), rand_marks());
      send_item(REQ_INSERT, 16'h0000, '1);
      send_item(REQ_INSERT, 16'hFFFF, '0);
      send_item(REQ_INSERT, rand_key(), rand_marks());
      send_item(REQ_DELETE, pick_stored_key(), rand_marks());
      send_item(REQ_INSERT, 16'hFFFF, rand_marks());
      send_item(REQ_INSERT, rand_key(), rand_marks());
      while (tbl_fill > 0) begin
         if ($urandom_range(0, 99) < 85) send_item(REQ_DELETE, pick_stored_key(), rand_marks());
         else send_item(REQ_DELETE, rand_key(), rand_marks());
      end
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_result_backpressure();
      idle_en = 1'b0;
      repeat (2) begin
         rsp_hold_request = 60;
         repeat (8) send_random_op();
      end
      idle_en = 1'b1;
   endtask

   // random mix, idle bursts first, back to back at the end
   task automatic test_random_mix();
      repeat (RANDOM_OPS - CALM_OPS) send_random_op();
      idle_en = 1'b0;
      repeat (CALM_OPS) send_random_op();
   endtask

   // result ready: random idle bursts plus requested long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_hold_request > 0) begin
            rsp_stall_left   = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (rsp_stall_left == 0 && idle_en && $urandom_range(0, 4) == 0) begin
            rsp_stall_left = $urandom_range(1, 7);
         end
         if (rsp_stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (predicted_outcomes.size() == 0) begin
            $error("result beat with no request pending");
            mismatch_count++;
         end else begin
            want = predicted_outcomes.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("position", want.position, rsp_bus.position);
            check_field("moves", want.moves, rsp_bus.moves);
            check_field("fill_count", want.fill_count, rsp_bus.fill_count);
         end
      end
   end

   // main sequence
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_INSERT;
      req_bus.key      = '0;
      req_bus.mark_a   = '0;
      req_bus.mark_b   = '0;
      req_bus.mark_c   = '0;
      req_bus.mark_d   = '0;
      req_bus.mark_e   = '0;
      rsp_bus.ready    = 1'b0;
      tbl_fill         = 0;
      mismatch_count   = 0;
      rsp_hold_request = 0;
      rsp_stall_left   = 0;
      idle_en          = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_result_backpressure();
      test_random_mix();

      req_bus.valid <= 1'b0;
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
